### rtl/core/palette_rle_sprite_row_decoder_defines.svh
// assertion macros for the palette run-length sprite row decoder
`ifndef PALETTE_RLE_SPRITE_ROW_DECODER_DEFINES_SVH
`define PALETTE_RLE_SPRITE_ROW_DECODER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define PRSD_ASSERT_IMP(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error(msg);
// antecedent implies consequent in the next cycle
`define PRSD_ASSERT_NXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error(msg);
`else
`define PRSD_ASSERT_IMP(lbl, ant, con, msg)
`define PRSD_ASSERT_NXT(lbl, ant, con, msg)
`endif
`endif

### rtl/core/prsd_pkg.sv
// shared types and constants of the sprite row decoder
`default_nettype none
package prsd_pkg;

  // input commands
  typedef enum logic [1:0] {
    CMD_PAL  = 2'd0,
    CMD_ROW  = 2'd1,
    CMD_BYTE = 2'd2
  } cmd_t;

  // stream parser phase
  typedef enum logic [2:0] {
    PH_HEADER       = 3'd0,
    PH_SINGLE_INDEX = 3'd1,
    PH_REP_ALPHA    = 3'd2,
    PH_REP_INDEX    = 3'd3,
    PH_LITERAL      = 3'd4,
    PH_RUN_INDEX    = 3'd5,
    PH_SKIP_TWO     = 3'd6,
    PH_DONE         = 3'd7
  } phase_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PAL,
    ST_RUN,
    ST_EDGE_RD,
    ST_EDGE_WR,
    ST_COPY,
    ST_COPY_EMIT
  } state_t;

  // header forms
  localparam logic [1:0] FORM_ALPHA   = 2'd0;
  localparam logic [1:0] FORM_LITERAL = 2'd1;
  localparam logic [1:0] FORM_REPEAT  = 2'd2;

  localparam logic [31:0] RGB_MASK    = 32'h00FF_FFFF;
  localparam logic [31:0] ALPHA_OPAQUE = 32'hFF00_0000;
  localparam logic [0:0]  KIND_PIXEL  = 1'b0;
  localparam logic [0:0]  KIND_DUP    = 1'b1;

endpackage
`default_nettype wire

### rtl/core/prsd_ram.sv
// generic single-port-write ram with registered read
`default_nettype none
module prsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/core/palette_rle_sprite_row_decoder.sv
// palette rle sprite row decoder: a run reads the palette, then writes one pixel per cycle
// while the result slot is free, through a shared row-write port; edge repair reads both banks
// and then writes; begin row runs a clearing pass over all MAX_WIDTH entries of the new current row;
// an empty row that copies the row above writes the copy and then reports a duplicate word
// synchronous active-low reset clears control state and then clears both row banks
// in a pass over all MAX_WIDTH entries during which no word is accepted
`default_nettype none
`include "palette_rle_sprite_row_decoder_defines.svh"
module palette_rle_sprite_row_decoder #(
  parameter int MAX_WIDTH = 512
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [9:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_first_row,
  input  wire logic [7:0]  in_pal_index,
  input  wire logic [31:0] in_pal_color,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic [8:0]       out_column,
  output logic [31:0]      out_pixel_color,
  output logic             out_last
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = (CW > 10) ? CW : 10;
  localparam int PAW = 8;

  prsd_pkg::state_t state_r, state_nxt;
  prsd_pkg::phase_t phase_r, phase_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [5:0]    run_r, run_nxt;
  logic [7:0]    alpha_r, alpha_nxt;
  logic          row_zero_r, row_zero_nxt;
  logic          at_start_r, at_start_nxt;
  logic          prev_empty_r, prev_empty_nxt;
  logic          sel_r, sel_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          clr_both_r, clr_both_nxt;
  logic [5:0]    rem_r, rem_nxt;
  logic          alpha_mode_r, alpha_mode_nxt;
  logic [31:0]   color_r, color_nxt;
  logic          above_ok_r, above_ok_nxt;
  logic [9:0]    row_width_r;
  logic          out_valid_r, out_valid_nxt;
  logic          out_kind_r, out_kind_nxt;
  logic [8:0]    out_column_r, out_column_nxt;
  logic [31:0]   out_color_r, out_color_nxt;
  logic          out_last_r, out_last_nxt;

  logic [CW-1:0] eff_w;
  logic [WW-1:0] rw_ext;
  logic [CW-1:0] tcol;
  logic          slot;
  logic          accept;
  logic          pal_we;
  logic [31:0]   pal_rdata;
  logic          we_cur, we_both;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic [AW-1:0] cur_raddr, prev_raddr;
  logic [AW-1:0] b0_raddr, b1_raddr;
  logic [31:0]   b0_rdata, b1_rdata;
  logic [31:0]   cur_rdata, prev_rdata;
  logic [31:0]   fixed;
  logic [1:0]    form;
  logic [5:0]    hcnt;

  // effective row width, capped at the bank depth
  assign rw_ext = WW'(row_width_r);
  assign eff_w  = (rw_ext > WW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(rw_ext);
  assign tcol   = col_r - CW'(1);

  assign in_ready = (state_r == prsd_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign slot     = !out_valid_r || out_ready;
  assign pal_we   = accept && (in_command == prsd_pkg::CMD_PAL);
  assign form     = in_data_byte[7:6];
  assign hcnt     = in_data_byte[5:0];

  // palette store
  prsd_ram #(.WIDTH(32), .DEPTH(256)) u_pal (
    .clk   (clk),
    .we    (pal_we),
    .waddr (in_pal_index[PAW-1:0]),
    .wdata (in_pal_color),
    .raddr (in_data_byte[PAW-1:0]),
    .rdata (pal_rdata)
  );

  // row bank read addressing, bank sel_r is the current row
  assign cur_raddr  = (state_r == prsd_pkg::ST_COPY) ? cnt_r[AW-1:0] : tcol[AW-1:0];
  assign prev_raddr = (state_r == prsd_pkg::ST_COPY) ? cnt_r[AW-1:0] : col_r[AW-1:0];
  assign b0_raddr   = sel_r ? prev_raddr : cur_raddr;
  assign b1_raddr   = sel_r ? cur_raddr : prev_raddr;
  assign cur_rdata  = sel_r ? b1_rdata : b0_rdata;
  assign prev_rdata = sel_r ? b0_rdata : b1_rdata;

  prsd_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_bank0 (
    .clk   (clk),
    .we    (we_both || (we_cur && !sel_r)),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (b0_raddr),
    .rdata (b0_rdata)
  );

  prsd_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_bank1 (
    .clk   (clk),
    .we    (we_both || (we_cur && sel_r)),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (b1_raddr),
    .rdata (b1_rdata)
  );

  // edge repair value for the pixel left of the position
  always_comb begin
    if (((cur_rdata & prsd_pkg::RGB_MASK) == 32'd0) && !row_zero_r) begin
      fixed = above_ok_r ? prev_rdata : 32'd0;
    end else begin
      fixed = cur_rdata | prsd_pkg::ALPHA_OPAQUE;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= 10'd512;
    end else if (cfg_wr_en) begin
      row_width_r <= cfg_wr_data;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= prsd_pkg::ST_CLEAR;
      phase_r      <= prsd_pkg::PH_HEADER;
      col_r        <= '0;
      run_r        <= '0;
      alpha_r      <= '0;
      row_zero_r   <= 1'b1;
      at_start_r   <= 1'b1;
      prev_empty_r <= 1'b1;
      sel_r        <= 1'b0;
      cnt_r        <= '0;
      clr_both_r   <= 1'b1;
      rem_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      col_r        <= col_nxt;
      run_r        <= run_nxt;
      alpha_r      <= alpha_nxt;
      row_zero_r   <= row_zero_nxt;
      at_start_r   <= at_start_nxt;
      prev_empty_r <= prev_empty_nxt;
      sel_r        <= sel_nxt;
      cnt_r        <= cnt_nxt;
      clr_both_r   <= clr_both_nxt;
      rem_r        <= rem_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    alpha_mode_r <= alpha_mode_nxt;
    color_r      <= color_nxt;
    above_ok_r   <= above_ok_nxt;
    out_kind_r   <= out_kind_nxt;
    out_column_r <= out_column_nxt;
    out_color_r  <= out_color_nxt;
    out_last_r   <= out_last_nxt;
  end

  // sequencer
  always_comb begin
    logic [CW:0] sum;
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    col_nxt        = col_r;
    run_nxt        = run_r;
    alpha_nxt      = alpha_r;
    row_zero_nxt   = row_zero_r;
    at_start_nxt   = at_start_r;
    prev_empty_nxt = prev_empty_r;
    sel_nxt        = sel_r;
    cnt_nxt        = cnt_r;
    clr_both_nxt   = clr_both_r;
    rem_nxt        = rem_r;
    alpha_mode_nxt = alpha_mode_r;
    color_nxt      = color_r;
    above_ok_nxt   = above_ok_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_kind_nxt   = out_kind_r;
    out_column_nxt = out_column_r;
    out_color_nxt  = out_color_r;
    out_last_nxt   = out_last_r;
    we_cur         = 1'b0;
    we_both        = 1'b0;
    waddr          = col_r[AW-1:0];
    wdata          = color_r;
    sum            = {1'b0, col_r} + (CW+1)'(hcnt);

    case (state_r)
      // zero the current bank, or both after reset
      prsd_pkg::ST_CLEAR: begin
        waddr   = cnt_r[AW-1:0];
        wdata   = 32'd0;
        we_both = clr_both_r;
        we_cur  = !clr_both_r;
        cnt_nxt = cnt_r + (AW+1)'(1);
        if (cnt_r == (AW+1)'(MAX_WIDTH - 1)) begin
          cnt_nxt   = '0;
          state_nxt = prsd_pkg::ST_IDLE;
        end
      end

      // take one word
      prsd_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_command)
            prsd_pkg::CMD_ROW: begin
              prev_empty_nxt = at_start_r;
              at_start_nxt   = 1'b1;
              row_zero_nxt   = in_first_row;
              sel_nxt        = !sel_r;
              col_nxt        = '0;
              phase_nxt      = prsd_pkg::PH_HEADER;
              run_nxt        = '0;
              alpha_nxt      = '0;
              cnt_nxt        = '0;
              clr_both_nxt   = 1'b0;
              state_nxt      = prsd_pkg::ST_CLEAR;
            end
            prsd_pkg::CMD_BYTE: begin
              case (phase_r)
                prsd_pkg::PH_HEADER: begin
                  if (in_data_byte == 8'd0) begin
                    phase_nxt = prsd_pkg::PH_DONE;
                    if (at_start_r && !row_zero_r && !prev_empty_r) begin
                      cnt_nxt   = '0;
                      state_nxt = prsd_pkg::ST_COPY;
                    end
                  end else begin
                    at_start_nxt = 1'b0;
                    case (form)
                      prsd_pkg::FORM_ALPHA: begin
                        if (in_data_byte[5]) begin
                          alpha_nxt = {in_data_byte[4:0], 3'b000};
                          phase_nxt = prsd_pkg::PH_SINGLE_INDEX;
                        end else begin
                          run_nxt   = {1'b0, in_data_byte[4:0]};
                          phase_nxt = prsd_pkg::PH_REP_ALPHA;
                        end
                      end
                      prsd_pkg::FORM_LITERAL: begin
                        run_nxt   = hcnt;
                        phase_nxt = (hcnt != 6'd0) ? prsd_pkg::PH_LITERAL
                                                   : prsd_pkg::PH_HEADER;
                      end
                      prsd_pkg::FORM_REPEAT: begin
                        run_nxt   = hcnt;
                        phase_nxt = prsd_pkg::PH_RUN_INDEX;
                      end
                      default: begin
                        if (hcnt == 6'd0) begin
                          run_nxt   = 6'd2;
                          phase_nxt = prsd_pkg::PH_SKIP_TWO;
                          if ((col_r != '0) && (tcol < eff_w)) begin
                            above_ok_nxt = (col_r < eff_w);
                            state_nxt    = prsd_pkg::ST_EDGE_RD;
                          end
                        end else if (sum > (CW+1)'(MAX_WIDTH)) begin
                          col_nxt = CW'(MAX_WIDTH);
                        end else begin
                          col_nxt = sum[CW-1:0];
                        end
                      end
                    endcase
                  end
                end
                prsd_pkg::PH_SINGLE_INDEX: begin
                  rem_nxt        = 6'd1;
                  alpha_mode_nxt = 1'b1;
                  phase_nxt      = prsd_pkg::PH_HEADER;
                  state_nxt      = prsd_pkg::ST_PAL;
                end
                prsd_pkg::PH_REP_ALPHA: begin
                  alpha_nxt = {in_data_byte[4:0], 3'b000};
                  phase_nxt = prsd_pkg::PH_REP_INDEX;
                end
                prsd_pkg::PH_REP_INDEX, prsd_pkg::PH_RUN_INDEX: begin
                  rem_nxt        = run_r;
                  alpha_mode_nxt = (phase_r == prsd_pkg::PH_REP_INDEX);
                  run_nxt        = '0;
                  phase_nxt      = prsd_pkg::PH_HEADER;
                  state_nxt      = prsd_pkg::ST_PAL;
                end
                prsd_pkg::PH_LITERAL: begin
                  rem_nxt        = 6'd1;
                  alpha_mode_nxt = 1'b0;
                  run_nxt        = run_r - 6'd1;
                  if (run_r == 6'd1) begin
                    phase_nxt = prsd_pkg::PH_HEADER;
                  end
                  state_nxt = prsd_pkg::ST_PAL;
                end
                prsd_pkg::PH_SKIP_TWO: begin
                  run_nxt = run_r - 6'd1;
                  if (run_r == 6'd1) begin
                    phase_nxt = prsd_pkg::PH_HEADER;
                  end
                end
                default: begin
                end
              endcase
            end
            default: begin
            end
          endcase
        end
      end

      // palette data is back, form the run color
      prsd_pkg::ST_PAL: begin
        color_nxt = alpha_mode_r ? {alpha_r, pal_rdata[23:0]} : pal_rdata;
        state_nxt = prsd_pkg::ST_RUN;
      end

      // one pixel per cycle through the row write port while the result slot is free
      prsd_pkg::ST_RUN: begin
        if (rem_r == 6'd0) begin
          state_nxt = prsd_pkg::ST_IDLE;
        end else if (col_r >= eff_w) begin
          // rest of the run falls past the width
          sum = {1'b0, col_r} + (CW+1)'(rem_r);
          col_nxt   = (sum > (CW+1)'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : sum[CW-1:0];
          rem_nxt   = '0;
          state_nxt = prsd_pkg::ST_IDLE;
        end else if (slot) begin
          we_cur         = 1'b1;
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = prsd_pkg::KIND_PIXEL;
          out_column_nxt = 9'(col_r);
          out_color_nxt  = color_r;
          out_last_nxt   = (rem_r == 6'd1) ||
                           (({1'b0, col_r} + (CW+1)'(1)) >= {1'b0, eff_w});
          col_nxt        = col_r + CW'(1);
          rem_nxt        = rem_r - 6'd1;
          if (rem_r == 6'd1) begin
            state_nxt = prsd_pkg::ST_IDLE;
          end
        end
      end

      // bank reads issued for edge repair
      prsd_pkg::ST_EDGE_RD: begin
        state_nxt = prsd_pkg::ST_EDGE_WR;
      end

      // write the repaired pixel and report it
      prsd_pkg::ST_EDGE_WR: begin
        waddr = tcol[AW-1:0];
        wdata = fixed;
        if (slot) begin
          we_cur         = 1'b1;
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = prsd_pkg::KIND_PIXEL;
          out_column_nxt = 9'(tcol);
          out_color_nxt  = fixed;
          out_last_nxt   = 1'b1;
          state_nxt      = prsd_pkg::ST_IDLE;
        end
      end

      // copy the row above into the current bank, write address trails read address by one
      prsd_pkg::ST_COPY: begin
        waddr   = cnt_r[AW-1:0] - AW'(1);
        wdata   = prev_rdata;
        we_cur  = (cnt_r != '0);
        cnt_nxt = cnt_r + (AW+1)'(1);
        if (cnt_r == (AW+1)'(MAX_WIDTH)) begin
          cnt_nxt   = '0;
          state_nxt = prsd_pkg::ST_COPY_EMIT;
        end
      end

      // report the row duplicate
      prsd_pkg::ST_COPY_EMIT: begin
        if (slot) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = prsd_pkg::KIND_DUP;
          out_column_nxt = 9'd0;
          out_color_nxt  = 32'd0;
          out_last_nxt   = 1'b1;
          state_nxt      = prsd_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = prsd_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_column      = out_column_r;
  assign out_pixel_color = out_color_r;
  assign out_last        = out_last_r;

  // checks
  `PRSD_ASSERT_IMP(a_dup_word_zero, out_valid_r && out_kind_r,
    (out_column_r == 9'd0) && (out_color_r == 32'd0), "duplicate word carries payload")
  `PRSD_ASSERT_IMP(a_col_bound, 1'b1, col_r <= CW'(MAX_WIDTH), "column past bank depth")
  `PRSD_ASSERT_NXT(a_run_done, (state_r == prsd_pkg::ST_RUN) && (rem_r == 6'd0),
    state_r == prsd_pkg::ST_IDLE, "empty run did not finish")

endmodule
`default_nettype wire

### sim/testbench.sv
// testbench for the palette run-length sprite row decoder
`timescale 1ns / 100ps
module testbench;

  localparam int MAXW = 512;
  localparam int WATCHDOG_LIMIT = 20000;

  // result word as compared
  typedef struct packed {
    logic        kind;
    logic [8:0]  column;
    logic [31:0] color;
    logic        last;
  } pix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [9:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_command = prsd_pkg::CMD_PAL;
  logic [7:0] in_data_byte = '0;
  logic in_first_row = 1'b0;
  logic [7:0] in_pal_index = '0;
  logic [31:0] in_pal_color = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_kind;
  logic [8:0] out_column;
  logic [31:0] out_pixel_color;
  logic out_last;

  always #5 clk = ~clk;

  palette_rle_sprite_row_decoder u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_data_byte(in_data_byte), .in_first_row(in_first_row),
    .in_pal_index(in_pal_index), .in_pal_color(in_pal_color),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_column(out_column), .out_pixel_color(out_pixel_color), .out_last(out_last)
  );

  // predicted decoder state
  logic [31:0] pal_mem [256];
  bit          pal_known [256];
  logic [31:0] cur_row [MAXW];
  logic [31:0] prev_row [MAXW];
  int unsigned col_pos;
  prsd_pkg::phase_t phase;
  int unsigned run_cnt;
  logic [7:0]  alpha_q;
  bit          row_zero, at_start, prev_empty;
  int unsigned width_reg;

  pix_t pixel_q[$];
  pix_t step_buf[$];
  int errors = 0;
  int stall_pct = 15;
  int idle_cnt = 0;
  bit timed_out = 0;

  function automatic int unsigned eff_w();
    return (width_reg > MAXW) ? MAXW : width_reg;
  endfunction

  function automatic void push_pix(logic kind, int unsigned c, logic [31:0] color);
    pix_t p;
    p.kind = kind; p.column = c[8:0]; p.color = color; p.last = 1'b0;
    step_buf.push_back(p);
  endfunction

  function automatic void move_col(int unsigned n);
    col_pos = (col_pos + n > MAXW) ? MAXW : col_pos + n;
  endfunction

  function automatic void put_px(logic [31:0] color);
    if (col_pos < eff_w()) begin
      cur_row[col_pos] = color;
      push_pix(prsd_pkg::KIND_PIXEL, col_pos, color);
    end
    move_col(1);
  endfunction

  function automatic void fix_edge();
    int unsigned w, t;
    logic [31:0] above;
    w = eff_w();
    if (col_pos == 0 || col_pos - 1 >= w) return;
    t = col_pos - 1;
    above = (col_pos < w) ? prev_row[col_pos] : 32'h0;
    if ((cur_row[t] & prsd_pkg::RGB_MASK) == 0 && !row_zero) cur_row[t] = above;
    else cur_row[t] = cur_row[t] | prsd_pkg::ALPHA_OPAQUE;
    push_pix(prsd_pkg::KIND_PIXEL, t, cur_row[t]);
  endfunction

  function automatic void parse_header(logic [7:0] b);
    logic [5:0] cnt;
    cnt = b[5:0];
    if (b == 8'h00) begin
      if (at_start && !row_zero && !prev_empty) begin
        for (int i = 0; i < MAXW; i++) cur_row[i] = prev_row[i];
        push_pix(prsd_pkg::KIND_DUP, 0, 32'h0);
      end
      phase = prsd_pkg::PH_DONE;
      return;
    end
    at_start = 0;
    case (b[7:6])
      prsd_pkg::FORM_ALPHA: begin
        if (b[5]) begin
          alpha_q = {b[4:0], 3'b000};
          phase = prsd_pkg::PH_SINGLE_INDEX;
        end else begin
          run_cnt = 32'(b[4:0]);
          phase = prsd_pkg::PH_REP_ALPHA;
        end
      end
      prsd_pkg::FORM_LITERAL: begin
        run_cnt = 32'(cnt);
        phase = (cnt != 0) ? prsd_pkg::PH_LITERAL : prsd_pkg::PH_HEADER;
      end
      prsd_pkg::FORM_REPEAT: begin
        run_cnt = 32'(cnt);
        phase = prsd_pkg::PH_RUN_INDEX;
      end
      default: begin
        if (cnt == 0) begin
          fix_edge();
          run_cnt = 2;
          phase = prsd_pkg::PH_SKIP_TWO;
        end else begin
          move_col(32'(cnt));
        end
      end
    endcase
  endfunction

  // predicts the pixel writes caused by one word
  function automatic void predict_word(logic [1:0] cmd, logic [7:0] b, logic fr,
                                       logic [7:0] pidx, logic [31:0] pcol);
    logic [31:0] color;
    step_buf.delete();
    if (cmd == prsd_pkg::CMD_PAL) begin
      pal_mem[pidx] = pcol;
      pal_known[pidx] = 1;
    end else if (cmd == prsd_pkg::CMD_ROW) begin
      prev_empty = at_start;
      for (int i = 0; i < MAXW; i++) begin
        prev_row[i] = cur_row[i];
        cur_row[i] = 32'h0;
      end
      col_pos = 0; phase = prsd_pkg::PH_HEADER; run_cnt = 0; alpha_q = 0;
      at_start = 1; row_zero = fr;
    end else if (cmd == prsd_pkg::CMD_BYTE) begin
      case (phase)
        prsd_pkg::PH_HEADER: parse_header(b);
        prsd_pkg::PH_SINGLE_INDEX: begin
          put_px((pal_mem[b] & prsd_pkg::RGB_MASK) | {alpha_q, 24'h0});
          phase = prsd_pkg::PH_HEADER;
        end
        prsd_pkg::PH_REP_ALPHA: begin
          alpha_q = {b[4:0], 3'b000};
          phase = prsd_pkg::PH_REP_INDEX;
        end
        prsd_pkg::PH_REP_INDEX, prsd_pkg::PH_RUN_INDEX: begin
          color = pal_mem[b];
          if (phase == prsd_pkg::PH_REP_INDEX)
            color = (color & prsd_pkg::RGB_MASK) | {alpha_q, 24'h0};
          for (int i = 0; i < run_cnt; i++) put_px(color);
          run_cnt = 0;
          phase = prsd_pkg::PH_HEADER;
        end
        prsd_pkg::PH_LITERAL: begin
          put_px(pal_mem[b]);
          run_cnt = (run_cnt - 1) & 6'h3F;
          if (run_cnt == 0) phase = prsd_pkg::PH_HEADER;
        end
        prsd_pkg::PH_SKIP_TWO: begin
          run_cnt = (run_cnt - 1) & 6'h3F;
          if (run_cnt == 0) phase = prsd_pkg::PH_HEADER;
        end
        default: ;
      endcase
    end
    if (step_buf.size() > 0) step_buf[step_buf.size() - 1].last = 1'b1;
    foreach (step_buf[i]) pixel_q.push_back(step_buf[i]);
  endfunction

  // sends one word and predicts its results
  task automatic send_word(logic [1:0] cmd, logic [7:0] b, logic fr = 0,
                           logic [7:0] pidx = 0, logic [31:0] pcol = 0);
    if ($urandom_range(99) < stall_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < stall_pct);
    end
    in_valid <= 1'b1;
    in_command <= cmd; in_data_byte <= b; in_first_row <= fr;
    in_pal_index <= pidx; in_pal_color <= pcol;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_word(cmd, b, fr, pidx, pcol);
  endtask

  task automatic send_byte(logic [7:0] b);
    send_word(prsd_pkg::CMD_BYTE, b);
  endtask

  function automatic logic [7:0] pick_index();
    logic [7:0] i;
    do i = 8'($urandom_range(255)); while (!pal_known[i]);
    return i;
  endfunction

  // result side backpressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    pix_t exp_p;
    if (rst_n && out_valid && out_ready) begin
      if (pixel_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: kind=%0d col=%0d color=%h last=%0d",
                   out_kind, out_column, out_pixel_color, out_last);
      end else begin
        exp_p = pixel_q.pop_front();
        if (exp_p.kind !== out_kind || exp_p.column !== out_column ||
            exp_p.color !== out_pixel_color || exp_p.last !== out_last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp kind=%0d col=%0d color=%h last=%0d, got %0d %0d %h %0d",
                     exp_p.kind, exp_p.column, exp_p.color, exp_p.last,
                     out_kind, out_column, out_pixel_color, out_last);
        end
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic drain();
    in_valid <= 1'b0;
    while (pixel_q.size() > 0) @(posedge clk);
    repeat (3 * MAXW) @(posedge clk);
  endtask

  task automatic set_width(int unsigned w);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w[9:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    width_reg = w;
    @(posedge clk);
  endtask

  task automatic load_palette();
    for (int i = 0; i < 16; i++) begin
      logic [31:0] c;
      c = (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom;
      if (i == 2) c = 32'h8000_0000;
      send_word(prsd_pkg::CMD_PAL, 8'($urandom), 0,
                (i < 2) ? 8'(i * 255) : 8'($urandom_range(255)), c);
    end
  endtask

  // every token form and the row special cases
  task automatic test_token_forms();
    set_width(512);
    load_palette();
    send_word(prsd_pkg::CMD_ROW, 0, 1);
    send_byte(8'h3F); send_byte(8'd255);           // single pixel, alpha 0xF8
    send_byte(8'h05); send_byte(8'hFF); send_byte(8'd0); // repeat with alpha byte
    send_byte(8'h43); send_byte(8'd0); send_byte(8'd255); send_byte(pick_index());
    send_byte(8'h40);                              // empty literal
    send_byte(8'h80); send_byte(8'd0);             // empty repeat
    send_byte(8'hBF); send_byte(8'd255);           // long repeat
    send_byte(8'hC0); send_byte(8'h12); send_byte(8'h34); // edge repair, row zero
    send_byte(8'hC4);                              // skip
    send_byte(8'h00); send_byte(8'h55);            // end of row, then ignored byte
    send_word(prsd_pkg::CMD_ROW, 0, 0);
    send_byte(8'hC3); send_byte(8'hC0); send_byte(8'h0); send_byte(8'h0); // repair from above
    send_word(prsd_pkg::CMD_ROW, 0, 0);
    send_byte(8'h00);                              // empty row copies above
    send_word(prsd_pkg::CMD_ROW, 0, 0);
    send_word(prsd_pkg::CMD_ROW, 0, 0);            // row with no bytes
    send_byte(8'h00);
    send_word(2'd3, 8'hAA, 1, 8'hFF, 32'hFFFF_FFFF); // unknown command
    drain();
  endtask

  // width extremes: drops past the width and a zero width
  task automatic test_width_limits();
    set_width(1);
    send_word(prsd_pkg::CMD_ROW, 0, 0);
    send_byte(8'h84); send_byte(pick_index());
    send_byte(8'hC0); send_byte(8'h0); send_byte(8'h0);
    drain();
    set_width(0);
    send_word(prsd_pkg::CMD_ROW, 0, 1);
    send_byte(8'h82); send_byte(pick_index());
    drain();
    set_width(1023);
    send_word(prsd_pkg::CMD_ROW, 0, 0);
    send_byte(8'hFF);
    for (int i = 0; i < 8; i++) send_byte(8'hFF);  // saturate at the end
    send_byte(8'hBF); send_byte(pick_index());
    send_byte(8'hC0); send_byte(8'h0); send_byte(8'h0);
    drain();
  endtask

  // random well-formed rows with some noise
  task automatic test_random_rows(int n_words);
    int sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(9) == 0)
        send_word(prsd_pkg::CMD_PAL, 8'($urandom), 1'($urandom), 8'($urandom), $urandom);
      send_word(prsd_pkg::CMD_ROW, 8'($urandom), $urandom_range(3) == 0);
      sent += 2;
      for (int t = $urandom_range(6); t > 0; t--) begin
        int f = $urandom_range(7);
        case (f)
          0: begin send_byte({3'b001, 5'($urandom)}); send_byte(pick_index()); sent += 2; end
          1: begin
            send_byte({3'b000, 5'($urandom_range(1, 31))}); send_byte(8'($urandom));
            send_byte(pick_index()); sent += 3;
          end
          2: begin
            int k = $urandom_range(0, 6);
            send_byte({2'b01, 6'(k)});
            for (int j = 0; j < k; j++) send_byte(pick_index());
            sent += 1 + k;
          end
          3: begin send_byte({2'b10, 6'($urandom)}); send_byte(pick_index()); sent += 2; end
          4: begin send_byte({2'b11, 6'($urandom_range(1, 63))}); sent++; end
          5: begin
            send_byte(8'hC0); send_byte(8'($urandom)); send_byte(8'($urandom)); sent += 3;
          end
          6: begin send_byte(8'h00); sent++; end
          default: begin
            if (phase == prsd_pkg::PH_DONE) begin send_byte(8'($urandom)); sent++; end
          end
        endcase
      end
      if ($urandom_range(1)) begin send_byte(8'h00); sent++; end
    end
  endtask

  initial begin
    for (int i = 0; i < 256; i++) begin pal_mem[i] = 0; pal_known[i] = 0; end
    for (int i = 0; i < MAXW; i++) begin cur_row[i] = 0; prev_row[i] = 0; end
    col_pos = 0; phase = prsd_pkg::PH_HEADER; run_cnt = 0; alpha_q = 0;
    row_zero = 1; at_start = 1; prev_empty = 1; width_reg = 512;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_token_forms();
    test_width_limits();
    set_width(37);
    test_random_rows(20);
    drain();
    set_width(512);
    stall_pct = 0;
    test_random_rows(20);
    stall_pct = 15;
    test_random_rows(20);
    drain();
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule

### filelist.f
+incdir+rtl/core
rtl/core/prsd_pkg.sv
rtl/core/prsd_ram.sv
rtl/core/palette_rle_sprite_row_decoder.sv
sim/testbench.sv
